// ===== hw/rtl/hsc_pkg.sv =====
// Package for the extended Hamming SEC-DED codec.
// Holds the status codes, request codes and elaboration-time layout helpers.
// No dependencies.
`default_nettype none

package hsc_pkg;

	localparam logic REQ_ENCODE = 1'b0;
	localparam logic REQ_DECODE = 1'b1;

	localparam logic [1:0] STATUS_CLEAN     = 2'd0;
	localparam logic [1:0] STATUS_CORRECTED = 2'd1;
	localparam logic [1:0] STATUS_UNCORR    = 2'd2;

	// Least count of check bits k with 2^k >= data bits + k + 1.
	function automatic int check_count(input int data_bits);
		int kk;
		kk = 0;
		for (int k = 0; k < 8; k++) begin
			if ((1 << k) < data_bits + k + 1) begin
				kk = k + 1;
			end
		end
		return kk;
	endfunction

	function automatic bit is_pow2(input int x);
		return (x != 0) && ((x & (x - 1)) == 0);
	endfunction

	// Code word position of data bit d: the d-th position above zero that is
	// not a power of two.
	function automatic int data_pos(input int d);
		int cnt;
		int pos;
		cnt = 0;
		pos = 0;
		for (int j = 1; j < 128; j++) begin
			if (!is_pow2(j)) begin
				if (cnt == d) begin
					pos = j;
				end
				cnt++;
			end
		end
		return pos;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hamming_secded_codec.sv =====
// Top level of the extended Hamming SEC-DED codec.
// Depends on hsc_pkg for status codes and code word layout helpers.
// One input register stage and one result register stage.
`default_nettype none

// The codec takes one request per cycle unless out_ready holds it back, and
// returns its results in order. A request either encodes data_in into an
// N-bit code word (N = DATA_BITS + check bits + 1, bit 0 the overall even
// parity) or decodes code_in, correcting any single error and flagging
// double errors, or a syndrome pointing outside the word, as uncorrectable.
// Throughput is one request per cycle: the work is a set of XOR trees
// between the input register and the result register, and the result
// register lets a new request in while a finished result waits on out_ready.
module hamming_secded_codec
	import hsc_pkg::*;
#(
	parameter int DATA_BITS = 8,
	localparam int SYN_W    = check_count(DATA_BITS),
	localparam int CODE_W   = DATA_BITS + SYN_W + 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 req_type,
	input  wire logic [DATA_BITS-1:0] data_in,
	input  wire logic [CODE_W-1:0]    code_in,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [CODE_W-1:0]         code_out,
	output logic [DATA_BITS-1:0]      data_out,
	output logic [1:0]                status
);

	logic                 valid_s1, valid_s2;
	logic                 req_s1, req_s2;
	logic [DATA_BITS-1:0] data_s1, data_s2;
	logic [CODE_W-1:0]    code_s1, code_s2;
	logic [1:0]           status_s2;
	logic                 adv_s1, adv_s2;

	logic [CODE_W-1:0]    enc_word;
	logic [SYN_W-1:0]     enc_syn;
	logic [CODE_W-1:0]    dec_word;
	logic [SYN_W-1:0]     dec_syn;
	logic                 dec_par;
	logic                 syn_in_range;
	logic [DATA_BITS-1:0] dec_data;
	logic [CODE_W-1:0]    res_code;
	logic [DATA_BITS-1:0] res_data;
	logic [1:0]           res_status;

	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			req_s1  <= req_type;
			data_s1 <= data_in;
			code_s1 <= code_in;
		end
		if (adv_s2 && valid_s1) begin
			req_s2    <= req_s1;
			code_s2   <= res_code;
			data_s2   <= res_data;
			status_s2 <= res_status;
		end
	end

	// Encode: scatter the data, then the syndrome of the data-only word gives
	// every check bit at once.
	always_comb begin
		enc_word = '0;
		for (int d = 0; d < DATA_BITS; d++) begin
			enc_word[data_pos(d)] = data_s1[d];
		end
		enc_syn = '0;
		for (int j = 1; j < CODE_W; j++) begin
			if (enc_word[j]) begin
				enc_syn = enc_syn ^ SYN_W'(j);
			end
		end
		for (int i = 0; i < SYN_W; i++) begin
			enc_word[1 << i] = enc_syn[i];
		end
		enc_word[0] = ^enc_word[CODE_W-1:1];
	end

	// Decode: syndrome and overall parity, then a single flip when it is safe.
	always_comb begin
		dec_syn = '0;
		for (int j = 1; j < CODE_W; j++) begin
			if (code_s1[j]) begin
				dec_syn = dec_syn ^ SYN_W'(j);
			end
		end
		dec_par      = ^code_s1;
		syn_in_range = {1'b0, dec_syn} < (SYN_W+1)'(CODE_W);
		dec_word     = code_s1;
		for (int j = 1; j < CODE_W; j++) begin
			if (SYN_W'(j) == dec_syn) begin
				dec_word[j] = ~code_s1[j];
			end
		end
		dec_data = '0;
		for (int d = 0; d < DATA_BITS; d++) begin
			dec_data[d] = dec_word[data_pos(d)];
		end
	end

	always_comb begin
		res_code   = '0;
		res_data   = '0;
		res_status = STATUS_CLEAN;
		if (req_s1 == REQ_ENCODE) begin
			res_code = enc_word;
		end else if (dec_syn == '0) begin
			// A lone error in the parity bit leaves the data intact.
			res_data   = dec_data;
			res_status = dec_par ? STATUS_CORRECTED : STATUS_CLEAN;
		end else if (dec_par && syn_in_range) begin
			res_data   = dec_data;
			res_status = STATUS_CORRECTED;
		end else begin
			res_status = STATUS_UNCORR;
		end
	end

	assign out_valid = valid_s2;
	assign code_out  = code_s2;
	assign data_out  = data_s2;
	assign status    = status_s2;

	a_enc_even_parity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && req_s2 == REQ_ENCODE |-> !(^code_out) && status == STATUS_CLEAN)
		else $error("encoded word does not have even parity");

	a_dec_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && req_s2 == REQ_DECODE |-> code_out == '0)
		else $error("decode result carries a code word");

	a_uncorr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_UNCORR |-> data_out == '0)
		else $error("uncorrectable result carries data");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted request lost from input stage");

endmodule

`default_nettype wire

// ===== tb/hamming_secded_codec_tb.sv =====
// Self-checking testbench for the extended Hamming SEC-DED codec (13,8).
// Drives encode and decode requests through valid/ready and checks every result.
// Depends on hsc_pkg and the hamming_secded_codec RTL.
`default_nettype none

module hamming_secded_codec_tb;
	import hsc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DATA_W    = 8;
	localparam int CODE_W    = 13;
	localparam int CYCLE_CAP = 200000;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [DATA_W-1:0] data;
		logic [1:0]        st;
	} codec_result_t;

	// Keeps the expected codec results in request order and checks the outputs.
	class codec_scoreboard;
		codec_result_t awaited[$];
		int bad_cnt;

		function logic [CODE_W-1:0] hamming_encode(logic [DATA_W-1:0] d);
			logic [CODE_W-1:0] w;
			logic b;
			int k;
			w = '0;
			k = 0;
			for (int j = 1; j < CODE_W; j++) begin
				if ((j & (j - 1)) != 0) begin
					w[j] = d[k];
					k++;
				end
			end
			for (int p = 1; p < CODE_W; p = p << 1) begin
				b = 1'b0;
				for (int j = 1; j < CODE_W; j++) begin
					if (j != p && (j & p) != 0) begin
						b = b ^ w[j];
					end
				end
				w[p] = b;
			end
			w[0] = ^w[CODE_W-1:1];
			return w;
		endfunction

		function logic [DATA_W-1:0] data_field(logic [CODE_W-1:0] w);
			logic [DATA_W-1:0] d;
			int k;
			d = '0;
			k = 0;
			for (int j = 1; j < CODE_W; j++) begin
				if ((j & (j - 1)) != 0) begin
					d[k] = w[j];
					k++;
				end
			end
			return d;
		endfunction

		function codec_result_t secded_result(logic rt, logic [DATA_W-1:0] d,
				logic [CODE_W-1:0] c);
			codec_result_t r;
			logic [CODE_W-1:0] w;
			int syn;
			logic par;
			r = '0;
			if (rt == REQ_ENCODE) begin
				r.code = hamming_encode(d);
			end else begin
				w = c;
				syn = 0;
				par = 1'b0;
				for (int j = 0; j < CODE_W; j++) begin
					if (w[j]) begin
						par = ~par;
						syn = syn ^ j;
					end
				end
				if (syn == 0) begin
					// A zero syndrome with odd parity means only bit 0 was hit.
					r.data = data_field(w);
					r.st = par ? STATUS_CORRECTED : STATUS_CLEAN;
				end else if (par && syn < CODE_W) begin
					w[syn] = ~w[syn];
					r.data = data_field(w);
					r.st = STATUS_CORRECTED;
				end else begin
					r.st = STATUS_UNCORR;
				end
			end
			return r;
		endfunction

		function void note_request(logic rt, logic [DATA_W-1:0] d, logic [CODE_W-1:0] c);
			awaited.push_back(secded_result(rt, d, c));
		endfunction

		function void check_result(logic [CODE_W-1:0] code, logic [DATA_W-1:0] data,
				logic [1:0] st);
			codec_result_t want;
			if (awaited.size() == 0) begin
				bad_cnt++;
				if (bad_cnt <= 10) begin
					$display("unexpected result: code %h data %h status %0d", code, data, st);
				end
				return;
			end
			want = awaited.pop_front();
			if (want.code !== code || want.data !== data || want.st !== st) begin
				bad_cnt++;
				if (bad_cnt <= 10) begin
					$display({"mismatch: expected code %h data %h status %0d, ",
						"got code %h data %h status %0d"},
						want.code, want.data, want.st, code, data, st);
				end
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              req_type = REQ_ENCODE;
	logic [DATA_W-1:0] data_in = '0;
	logic [CODE_W-1:0] code_in = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [CODE_W-1:0] code_out;
	logic [DATA_W-1:0] data_out;
	logic [1:0]        status;

	codec_scoreboard codec_sb = new();
	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	int hold_cnt = 0;
	int cycle_cnt = 0;

	hamming_secded_codec uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .data_in(data_in), .code_in(code_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.code_out(code_out), .data_out(data_out), .status(status)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_CAP) begin
			$display("hamming_secded_codec_tb failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			codec_sb.note_request(req_type, data_in, code_in);
		end
		if (arst_n && out_valid && out_ready) begin
			codec_sb.check_result(code_out, data_out, status);
		end
	end

	// The receiver holds off while hold_cnt counts down when asked, otherwise stalls at random.
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			out_ready = 1'b0;
			hold_cnt--;
		end else begin
			out_ready = ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance with
	// valid still high, so back-to-back requests never drop it.
	task automatic send_request(input logic rt, input logic [DATA_W-1:0] d,
			input logic [CODE_W-1:0] c);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		req_type = rt;
		data_in = d;
		code_in = c;
		do begin
			@(posedge clk);
		end while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_random_request();
		logic [CODE_W-1:0] w;
		int kind;
		int flips;
		kind = $urandom_range(9);
		if (kind < 4) begin
			send_request(REQ_ENCODE, DATA_W'($urandom), CODE_W'($urandom));
		end else if (kind < 9) begin
			// A proper code word with up to three bits flipped.
			w = codec_sb.hamming_encode(DATA_W'($urandom));
			flips = $urandom_range(3);
			repeat (flips) begin
				w[$urandom_range(CODE_W - 1)] ^= 1'b1;
			end
			send_request(REQ_DECODE, DATA_W'($urandom), w);
		end else begin
			send_request(REQ_DECODE, DATA_W'($urandom), CODE_W'($urandom));
		end
	endtask

	task automatic drain_results();
		in_valid = 1'b0;
		while (codec_sb.awaited.size() != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		logic [CODE_W-1:0] good;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_request(REQ_ENCODE, 8'h00, CODE_W'($urandom));
		send_request(REQ_ENCODE, 8'hFF, CODE_W'($urandom));
		send_request(REQ_ENCODE, 8'h01, CODE_W'($urandom));
		send_request(REQ_ENCODE, 8'h80, CODE_W'($urandom));
		send_request(REQ_ENCODE, 8'hA5, CODE_W'($urandom));
		send_request(REQ_ENCODE, 8'h5A, CODE_W'($urandom));
		good = codec_sb.hamming_encode(8'hA5);
		send_request(REQ_DECODE, DATA_W'($urandom), 13'h0000);
		send_request(REQ_DECODE, DATA_W'($urandom), 13'h1FFF);
		send_request(REQ_DECODE, DATA_W'($urandom), 13'h0001);
		send_request(REQ_DECODE, DATA_W'($urandom), good);
		send_request(REQ_DECODE, DATA_W'($urandom), good ^ 13'h0001);
		send_request(REQ_DECODE, DATA_W'($urandom), good ^ 13'h0008);
		send_request(REQ_DECODE, DATA_W'($urandom), good ^ 13'h1000);
		send_request(REQ_DECODE, DATA_W'($urandom), good ^ 13'h0100);
		send_request(REQ_DECODE, DATA_W'($urandom), good ^ 13'h0204);
		// Three flips each, whose syndromes land past the top of the word.
		send_request(REQ_DECODE, DATA_W'($urandom), good ^ 13'h0112);
		send_request(REQ_DECODE, DATA_W'($urandom),
			codec_sb.hamming_encode(8'hFF) ^ 13'h0114);
		// Even parity with a syndrome of fifteen.
		send_request(REQ_DECODE, DATA_W'($urandom),
			codec_sb.hamming_encode(8'h00) ^ 13'h0116);

		repeat (70) send_random_request();

		// Long receiver hold-off while requests keep coming, so the codec backs up.
		hold_cnt = 60;
		repeat (30) send_random_request();
		drain_results();

		snd_idle_pct = 86;
		rcv_stall_pct = 0;
		repeat (110) send_random_request();
		drain_results();

		snd_idle_pct = 0;
		rcv_stall_pct = 86;
		repeat (110) send_random_request();
		drain_results();

		snd_idle_pct = 11;
		rcv_stall_pct = 11;
		repeat (110) send_random_request();
		drain_results();

		rcv_stall_pct = 0;
		repeat (8) @(negedge clk);
		if (codec_sb.bad_cnt == 0 && codec_sb.awaited.size() == 0) begin
			$display("hamming_secded_codec_tb passed");
		end else begin
			$display("hamming_secded_codec_tb failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/hsc_pkg.sv
hw/rtl/hamming_secded_codec.sv
tb/hamming_secded_codec_tb.sv
